[rtl/core/rgb_to_hsv_converter_unit_defines.svh]
`ifndef RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_DEFINES_SVH

// Clocked assertion, masked while in reset.
`define HSV_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that holds whenever a result request is presented.
`define HSV_ASSERT_VALID(name, cond, msg) \
  `HSV_ASSERT(name, valid_o |-> (cond), msg)

`endif

[rtl/core/hsv_pkg.sv]
`default_nettype none

package hsv_pkg;

  localparam int RGB_W     = 8;
  localparam int HUE_W     = 15;
  localparam int SAT_W     = 16;
  localparam int SAT_FRAC_W = 15;
  localparam int HUE_NUM_W = 20;

  // Restoring divider: quotient bits resolved one per stage.
  localparam int DIV_STEPS = 16;
  localparam int DIV_DEN_W = RGB_W;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_STEPS;

  localparam logic [HUE_W-1:0] HUE_PER_SECTOR  = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_BASE_GREEN  = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BASE_BLUE   = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL_CIRCLE = 15'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

endpackage

`default_nettype wire

[rtl/core/rgb_to_hsv_converter_unit.sv]
// Pipeline from an accepted request to valid_o: two setup stages,
//   16 restoring-divider stages for hue and saturation, one output stage.
// Throughput: one pixel per cycle; the whole pipe holds while an output
//   request is stalled.
// Reset: asynchronous, active low; clears all valid bits, data is not reset.
`default_nettype none

module rgb_to_hsv_converter_unit import hsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [RGB_W-1:0] red_i,
  input  logic [RGB_W-1:0] green_i,
  input  logic [RGB_W-1:0] blue_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [HUE_W-1:0] hue_o,
  output logic [SAT_W-1:0] saturation_o,
  output logic [RGB_W-1:0] brightness_o
);

  typedef struct packed {
    sector_e          sec;
    logic             neg;
    logic [RGB_W-1:0] mx;
    logic [RGB_W-1:0] diff;
    logic [RGB_W-1:0] nabs;
  } prep_t;

  typedef struct packed {
    logic [HUE_W-1:0] base;
    logic             neg;
    logic             grey;
    logic             black;
    logic [RGB_W-1:0] mx;
  } side_t;

  logic adv;

  prep_t a_d, a_q;
  logic  a_vld_q;

  side_t                b_side_d, b_side_q;
  logic                 b_vld_q;
  logic [HUE_NUM_W-1:0] hue_num;
  logic [DIV_NUM_W-1:0] hue_num_q, sat_num_q;
  logic [DIV_DEN_W-1:0] hue_den_q, sat_den_q;

  side_t side_q [DIV_STEPS];
  logic  [DIV_STEPS-1:0] vld_q;

  logic [DIV_STEPS-1:0] hue_quo, sat_quo;
  logic [HUE_W-1:0]     hue_d, hue_q;
  logic [SAT_W-1:0]     sat_d, sat_q;
  logic [RGB_W-1:0]     bri_q;
  logic                 out_vld_q;

  assign adv     = !(out_vld_q && stall_i);
  assign stall_o = !adv;

  // Stage A: max, min, sector and sector difference.
  always_comb begin
    logic [RGB_W-1:0] mn;
    a_d    = '0;
    a_d.mx = red_i;
    mn     = red_i;
    if (green_i > a_d.mx) a_d.mx = green_i;
    if (blue_i > a_d.mx)  a_d.mx = blue_i;
    if (green_i < mn)     mn = green_i;
    if (blue_i < mn)      mn = blue_i;
    a_d.diff = a_d.mx - mn;
    if (a_d.mx == red_i) begin
      a_d.sec  = SEC_RED;
      a_d.neg  = (green_i < blue_i);
      a_d.nabs = a_d.neg ? (blue_i - green_i) : (green_i - blue_i);
    end else if (a_d.mx == green_i) begin
      a_d.sec  = SEC_GREEN;
      a_d.neg  = (blue_i < red_i);
      a_d.nabs = a_d.neg ? (red_i - blue_i) : (blue_i - red_i);
    end else begin
      a_d.sec  = SEC_BLUE;
      a_d.neg  = (red_i < green_i);
      a_d.nabs = a_d.neg ? (green_i - red_i) : (red_i - green_i);
    end
  end

  // Stage B: dividends and hue base. Negative sector terms use a ceiling
  // quotient so that base - q matches the floor.
  always_comb begin
    hue_num = HUE_NUM_W'(a_q.nabs) * HUE_NUM_W'(HUE_PER_SECTOR);
    if (a_q.neg) begin
      hue_num = hue_num + HUE_NUM_W'(a_q.diff) - HUE_NUM_W'(1);
    end
    b_side_d.neg   = a_q.neg;
    b_side_d.grey  = (a_q.diff == '0);
    b_side_d.black = (a_q.mx == '0);
    b_side_d.mx    = a_q.mx;
    case (a_q.sec)
      SEC_RED:   b_side_d.base = a_q.neg ? HUE_FULL_CIRCLE : '0;
      SEC_GREEN: b_side_d.base = HUE_BASE_GREEN;
      SEC_BLUE:  b_side_d.base = HUE_BASE_BLUE;
      default:   b_side_d.base = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q       <= a_d;
      b_side_q  <= b_side_d;
      hue_num_q <= DIV_NUM_W'(hue_num);
      sat_num_q <= DIV_NUM_W'({a_q.diff, {SAT_FRAC_W{1'b0}}});
      hue_den_q <= a_q.diff;
      sat_den_q <= a_q.mx;
      side_q[0] <= b_side_q;
      for (int s = 1; s < DIV_STEPS; s++) begin
        side_q[s] <= side_q[s-1];
      end
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= side_q[DIV_STEPS-1].mx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= valid_i;
      b_vld_q   <= a_vld_q;
      vld_q     <= {vld_q[DIV_STEPS-2:0], b_vld_q};
      out_vld_q <= vld_q[DIV_STEPS-1];
    end
  end

  hsv_div u_hue_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (hue_num_q),
    .den_i (hue_den_q),
    .quo_o (hue_quo)
  );

  hsv_div u_sat_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (sat_num_q),
    .den_i (sat_den_q),
    .quo_o (sat_quo)
  );

  // Output stage.
  always_comb begin
    logic [HUE_W-1:0] q;
    q = hue_quo[HUE_W-1:0];
    if (side_q[DIV_STEPS-1].grey) begin
      hue_d = '0;
    end else if (side_q[DIV_STEPS-1].neg) begin
      hue_d = side_q[DIV_STEPS-1].base - q;
    end else begin
      hue_d = side_q[DIV_STEPS-1].base + q;
    end
    sat_d = side_q[DIV_STEPS-1].black ? '0 : SAT_W'(sat_quo);
  end

  assign valid_o      = out_vld_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bri_q;

endmodule

`default_nettype wire

[rtl/core/hsv_div.sv]
`default_nettype none

module hsv_div import hsv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_STEPS-1:0] quo_o
);

  // Requires num_i / den_i < 2**DIV_STEPS.
  logic [DIV_DEN_W-1:0] rem_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] low_q [DIV_STEPS];
  logic [DIV_STEPS-1:0] quo_q [DIV_STEPS];
  logic [DIV_DEN_W-1:0] den_q [DIV_STEPS];

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [DIV_DEN_W-1:0] rem_in;
    logic [DIV_STEPS-1:0] low_in;
    logic [DIV_STEPS-1:0] quo_in;
    logic [DIV_DEN_W-1:0] den_in;
    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   sub;
    logic                 fits;
    logic [DIV_DEN_W-1:0] rem_d;
    logic [DIV_STEPS-1:0] quo_d;

    if (s == 0) begin : g_first
      assign rem_in = num_i[DIV_NUM_W-1 -: DIV_DEN_W];
      assign low_in = num_i[DIV_STEPS-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      trial = {rem_in, low_in[DIV_STEPS-1]};
      sub   = trial - {1'b0, den_in};
      fits  = (trial >= {1'b0, den_in});
      rem_d = fits ? sub[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
      quo_d = {quo_in[DIV_STEPS-2:0], fits};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        low_q[s] <= {low_in[DIV_STEPS-2:0], 1'b0};
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STEPS-1];

endmodule

`default_nettype wire

[rtl/core/hsv_checker.sv]
`default_nettype none
`include "rgb_to_hsv_converter_unit_defines.svh"

module hsv_checker import hsv_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             valid_o,
  input logic             stall_i,
  input logic [HUE_W-1:0] hue_o,
  input logic [SAT_W-1:0] saturation_o,
  input logic [RGB_W-1:0] brightness_o
);

  `HSV_ASSERT(a_out_hold,
    valid_o && stall_i |=> valid_o && $stable(hue_o) && $stable(saturation_o)
      && $stable(brightness_o),
    "stalled result request changed")
  `HSV_ASSERT_VALID(a_hue_range, hue_o < HUE_FULL_CIRCLE, "hue out of range")
  `HSV_ASSERT_VALID(a_sat_range, saturation_o <= 16'd32768, "saturation above one")
  `HSV_ASSERT_VALID(a_grey_hue, saturation_o != '0 || hue_o == '0, "grey pixel with nonzero hue")
  `HSV_ASSERT_VALID(a_black_sat, brightness_o != '0 || saturation_o == '0, "black pixel saturated")

endmodule

bind rgb_to_hsv_converter_unit hsv_checker u_hsv_checker (.*);

`default_nettype wire

[dv/rgb_to_hsv_converter_unit_test.sv]
module rgb_to_hsv_converter_unit_test import hsv_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [RGB_W-1:0] red;
    logic [RGB_W-1:0] green;
    logic [RGB_W-1:0] blue;
  } rgb_pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [RGB_W-1:0] brightness;
  } hsv_color_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             valid_i = 1'b0;
  logic             stall_o;
  logic [RGB_W-1:0] red_i = '0;
  logic [RGB_W-1:0] green_i = '0;
  logic [RGB_W-1:0] blue_i = '0;
  logic             valid_o;
  logic             stall_i = 1'b0;
  logic [HUE_W-1:0] hue_o;
  logic [SAT_W-1:0] saturation_o;
  logic [RGB_W-1:0] brightness_o;

  rgb_pixel_t pixel_q[$];
  hsv_color_t hsv_expected_q[$];
  bit         pixel_taken;
  int         cyc;
  int         hold_left;
  int         mismatches;
  bit         calm;

  rgb_to_hsv_converter_unit dut (.*);

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  assign calm = cyc >= 450 && cyc < 750;

  function automatic hsv_color_t predict_hsv(rgb_pixel_t px);
    hsv_color_t res;
    int r;
    int g;
    int b;
    int hi;
    int lo;
    int diff;
    int num;
    int total;
    sector_e sector;
    r = px.red;
    g = px.green;
    b = px.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    diff = hi - lo;
    res = '0;
    res.brightness = hi[RGB_W-1:0];
    if (diff != 0) begin
      if (hi == r) begin
        sector = SEC_RED;
        num = g - b;
      end else if (hi == g) begin
        sector = SEC_GREEN;
        num = b - r;
      end else begin
        sector = SEC_BLUE;
        num = r - g;
      end
      total = int'(HUE_PER_SECTOR) * num;
      case (sector)
        SEC_GREEN: total += int'(HUE_BASE_GREEN) * diff;
        SEC_BLUE:  total += int'(HUE_BASE_BLUE) * diff;
        default:   ;
      endcase
      if (total < 0) total += int'(HUE_FULL_CIRCLE) * diff;
      res.hue = HUE_W'(total / diff);
    end
    if (hi != 0) res.saturation = SAT_W'((diff * 32768) / hi);
    return res;
  endfunction

  // request monitor and result checker
  always @(posedge clk_i) begin : hsv_monitor
    hsv_color_t want;
    cyc <= cyc + 1;
    pixel_taken = rst_ni && valid_i && !stall_o;
    if (pixel_taken) hsv_expected_q.push_back(predict_hsv({red_i, green_i, blue_i}));
    if (rst_ni && valid_o && !stall_i) begin
      if (hsv_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: hue %0d sat %0d val %0d",
                   hue_o, saturation_o, brightness_o);
      end else begin
        want = hsv_expected_q.pop_front();
        if (hue_o !== want.hue || saturation_o !== want.saturation ||
            brightness_o !== want.brightness) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp hue %0d sat %0d val %0d, got hue %0d sat %0d val %0d",
                     want.hue, want.saturation, want.brightness,
                     hue_o, saturation_o, brightness_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin : pixel_driver
    bit go;
    if (pixel_taken) void'(pixel_q.pop_front());
    if (rst_ni && !(valid_i && !pixel_taken)) begin
      go = pixel_q.size() != 0 && (calm || $urandom_range(99) >= 10);
      valid_i <= go;
      if (go) begin
        red_i   <= pixel_q[0].red;
        green_i <= pixel_q[0].green;
        blue_i  <= pixel_q[0].blue;
      end
    end
  end

  // long hold-off lets the pipe fill and back up into the input
  always @(negedge clk_i) begin : result_receiver
    if (hold_left != 0) begin
      stall_i   <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (cyc == 200) begin
      stall_i   <= 1'b1;
      hold_left <= 80;
    end else begin
      stall_i <= !calm && $urandom_range(99) < 10;
    end
  end

  task automatic add_pixel(int r, int g, int b);
    pixel_q.push_back({RGB_W'(r), RGB_W'(g), RGB_W'(b)});
  endtask

  initial begin : stimulus
    int v;
    int w;
    // grey, black, white, primaries, ties, negative red hue, edges
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(1, 1, 1);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(255, 0, 1);
    add_pixel(255, 0, 254);
    add_pixel(1, 0, 0);
    add_pixel(0, 0, 1);
    add_pixel(0, 1, 0);
    add_pixel(255, 254, 0);
    add_pixel(254, 255, 0);
    add_pixel(0, 1, 255);
    add_pixel(1, 0, 255);
    add_pixel(255, 128, 0);
    add_pixel(0, 128, 255);
    add_pixel(170, 85, 85);
    add_pixel(200, 50, 100);
    add_pixel(255, 1, 0);
    repeat (750) begin
      v = $urandom_range(255);
      w = $urandom_range(255);
      case ($urandom_range(9))
        6, 7: begin
          case ($urandom_range(2))
            0: add_pixel(v, v, w);
            1: add_pixel(v, w, v);
            default: add_pixel(w, v, v);
          endcase
        end
        8: add_pixel(v, v ^ $urandom_range(3), v ^ $urandom_range(3));
        9: add_pixel($urandom_range(1) * 255, $urandom_range(1) * 255, w);
        default: add_pixel(v, w, $urandom_range(255));
      endcase
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (pixel_q.size() == 0);
    wait (hsv_expected_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** rgb_to_hsv_converter_unit: PASSED **");
    end else begin
      $display("** rgb_to_hsv_converter_unit: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("** rgb_to_hsv_converter_unit: FAILED **");
    $finish;
  end

endmodule
